[hw/rtl/wbaf_pkg.sv]
package wbaf_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int XW = 33;   // CORDIC x/y width, Q30 with headroom
  localparam int ZW = 34;   // CORDIC residual angle width
  localparam int KW = 34;   // rotation matrix coefficient width, Q30
  localparam int DEF_ANGLE_BITS = 16;
  localparam int DEF_FORCE_BITS = 32;
  localparam logic [2:0] MASK_RESET = 3'd7;
  localparam logic signed [XW-1:0] CORDIC_X0 = 33'sh026DD3B6A;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
  } cordic_t;

  // Arctangent of 2^-i in 2^-32 turn units.
  function automatic logic signed [ZW-1:0] atan_turn(input int i);
    logic [31:0] v;
    unique case (i)
      0: v = 32'h20000000;   1: v = 32'h12E4051D;   2: v = 32'h09FB385B;
      3: v = 32'h051111D4;   4: v = 32'h028B0D43;   5: v = 32'h0145D7E1;
      6: v = 32'h00A2F61E;   7: v = 32'h00517C55;   8: v = 32'h0028BE53;
      9: v = 32'h00145F2E;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
      12: v = 32'h00028BE6; 13: v = 32'h000145F3;  14: v = 32'h0000A2F9;
      15: v = 32'h0000517C; 16: v = 32'h000028BE;  17: v = 32'h0000145F;
      18: v = 32'h00000A2F; 19: v = 32'h00000517;  20: v = 32'h0000028B;
      21: v = 32'h00000145; 22: v = 32'h000000A2;  23: v = 32'h00000051;
      24: v = 32'h00000028; 25: v = 32'h00000014;  26: v = 32'h0000000A;
      27: v = 32'h00000005; 28: v = 32'h00000002;  29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return signed'({2'b00, v});
  endfunction

endpackage

[hw/rtl/wbaf_cordic_cell.sv]
module wbaf_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic             clk,
  input  logic             en,
  input  wbaf_pkg::cordic_t cell_in,
  output wbaf_pkg::cordic_t cell_out
);
  import wbaf_pkg::*;

  logic signed [XW-1:0] dx, dy;
  cordic_t cell_nxt, cell_r;

  always_comb begin
    dx = cell_in.y >>> STEP;
    dy = cell_in.x >>> STEP;
    cell_nxt.flip = cell_in.flip;
    if (!cell_in.z[ZW-1]) begin
      cell_nxt.x = cell_in.x - dx;
      cell_nxt.y = cell_in.y + dy;
      cell_nxt.z = cell_in.z - atan_turn(STEP);
    end else begin
      cell_nxt.x = cell_in.x + dx;
      cell_nxt.y = cell_in.y - dy;
      cell_nxt.z = cell_in.z + atan_turn(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule

[hw/rtl/wind_to_body_axis_force_core.sv]
// Wind-axis to body-axis force rotation.
// The input channel takes one beat per sample: angle of attack and sideslip
// as signed binary angles and the drag, side and lift forces in Q.8. The
// output channel gives one beat per sample with the body x, y and z forces
// (z positive down), each saturated to the signed force width.
// Sines and cosines come from two rows of 30 CORDIC cells, one cell per
// rotation step, followed by a coefficient multiply stage, a split force
// multiply stage, a sum stage and the rounding and saturating output stage.
// Throughput is one beat per cycle while the receiver takes beats: every
// stage is a single register, so a new sample enters each such cycle.
// The whole pipeline advances whenever the output register is empty or its
// beat is taken. While the receiver stalls with a beat waiting, everything
// holds and in_ready is low; nothing is lost or repeated.
// The force enable mask is sampled as a sample enters; a cleared bit makes
// that force count as zero. Reset empties the pipeline and sets the mask to
// enable all three forces.
module wind_to_body_axis_force_core #(
  parameter int ANGLE_BITS = wbaf_pkg::DEF_ANGLE_BITS,
  parameter int FORCE_BITS = wbaf_pkg::DEF_FORCE_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ANGLE_BITS-1:0] in_attack_angle,
  input  logic signed [ANGLE_BITS-1:0] in_sideslip_angle,
  input  logic signed [FORCE_BITS-1:0] in_drag_force,
  input  logic signed [FORCE_BITS-1:0] in_side_force,
  input  logic signed [FORCE_BITS-1:0] in_lift_force,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [FORCE_BITS-1:0] out_body_force_x,
  output logic signed [FORCE_BITS-1:0] out_body_force_y,
  output logic signed [FORCE_BITS-1:0] out_body_force_z
);
  import wbaf_pkg::*;

  localparam int NS  = CORDIC_STEPS;
  localparam int LO  = FORCE_BITS / 2;             // low slice of a force
  localparam int HI  = FORCE_BITS - LO;
  localparam int PLW = LO + 1 + KW;
  localparam int PHW = HI + KW;
  localparam int PW  = FORCE_BITS + KW + 2;         // sum of three products
  localparam int MW  = 2 * XW;                      // sine-cosine product

  logic [2:0] mask_r;
  logic       adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= MASK_RESET;
    end else if (cfg_we) begin
      mask_r <= cfg_wdata;
    end
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Entry: widen each angle to a 32-bit turn and fold the half plane.
  logic [31:0] a32, b32;
  cordic_t     seed_a, seed_b;

  always_comb begin
    a32 = 32'(unsigned'(in_attack_angle)) << (32 - ANGLE_BITS);
    b32 = 32'(unsigned'(in_sideslip_angle)) << (32 - ANGLE_BITS);
    seed_a.flip = a32[31] ^ a32[30];
    seed_b.flip = b32[31] ^ b32[30];
    seed_a.x = CORDIC_X0;
    seed_b.x = CORDIC_X0;
    seed_a.y = '0;
    seed_b.y = '0;
    seed_a.z = ZW'(signed'({a32[31] ^ seed_a.flip, a32[30:0]}));
    seed_b.z = ZW'(signed'({b32[31] ^ seed_b.flip, b32[30:0]}));
  end

  // Two rows of CORDIC cells plus the force and valid delay line beside them.
  cordic_t row_a [NS+1];
  cordic_t row_b [NS+1];
  logic                         v_r   [NS+4];
  logic signed [FORCE_BITS-1:0] frc_r [NS][3];

  assign row_a[0] = seed_a;
  assign row_b[0] = seed_b;

  for (genvar i = 0; i < NS; i++) begin : g_cell
    wbaf_cordic_cell #(.STEP(i)) u_cell_a (
      .clk(clk), .en(adv), .cell_in(row_a[i]), .cell_out(row_a[i+1]));
    wbaf_cordic_cell #(.STEP(i)) u_cell_b (
      .clk(clk), .en(adv), .cell_in(row_b[i]), .cell_out(row_b[i+1]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS + 4; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < NS + 4; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      frc_r[0][0] <= mask_r[0] ? in_drag_force : '0;
      frc_r[0][1] <= mask_r[1] ? in_side_force : '0;
      frc_r[0][2] <= mask_r[2] ? in_lift_force : '0;
      for (int i = 1; i < NS; i++) frc_r[i] <= frc_r[i-1];
    end
  end

  // Coefficient stage: the nine entries of the rotation matrix in Q30.
  logic signed [XW-1:0] sa, ca, sb, cb;
  logic signed [MW-1:0] p_cacb, p_casb, p_sacb, p_sasb;
  logic signed [KW-1:0] k_nxt [9];
  logic signed [KW-1:0] k_r   [9];

  always_comb begin
    ca = row_a[NS].flip ? -row_a[NS].x : row_a[NS].x;
    sa = row_a[NS].flip ? -row_a[NS].y : row_a[NS].y;
    cb = row_b[NS].flip ? -row_b[NS].x : row_b[NS].x;
    sb = row_b[NS].flip ? -row_b[NS].y : row_b[NS].y;
    p_cacb = (MW'(ca) * MW'(cb) + (MW'(1) <<< 29)) >>> 30;
    p_casb = (MW'(ca) * MW'(sb) + (MW'(1) <<< 29)) >>> 30;
    p_sacb = (MW'(sa) * MW'(cb) + (MW'(1) <<< 29)) >>> 30;
    p_sasb = (MW'(sa) * MW'(sb) + (MW'(1) <<< 29)) >>> 30;
    k_nxt[0] = -KW'(p_cacb);
    k_nxt[1] = -KW'(p_casb);
    k_nxt[2] = KW'(sa);
    k_nxt[3] = -KW'(sb);
    k_nxt[4] = KW'(cb);
    k_nxt[5] = '0;
    k_nxt[6] = -KW'(p_sacb);
    k_nxt[7] = -KW'(p_sasb);
    k_nxt[8] = -KW'(ca);
  end

  logic signed [FORCE_BITS-1:0] fk_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      k_r  <= k_nxt;
      fk_r <= frc_r[NS-1];
    end
  end

  // Force multiply stage, each force split into a signed high and an
  // unsigned low slice.
  logic signed [PLW-1:0] plo_r [9];
  logic signed [PHW-1:0] phi_r [9];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 9; j++) begin
        plo_r[j] <= PLW'(signed'({1'b0, fk_r[j%3][LO-1:0]})) * PLW'(k_r[j]);
        phi_r[j] <= PHW'(signed'(fk_r[j%3][FORCE_BITS-1:LO])) * PHW'(k_r[j]);
      end
    end
  end

  // Sum stage: exact sum of three products for each axis.
  logic signed [PW-1:0] sum_nxt [3];
  logic signed [PW-1:0] sum_r   [3];

  always_comb begin
    for (int o = 0; o < 3; o++) begin
      sum_nxt[o] = '0;
      for (int t = 0; t < 3; t++) begin
        sum_nxt[o] = sum_nxt[o] + (PW'(phi_r[o*3+t]) <<< LO) + PW'(plo_r[o*3+t]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= sum_nxt;
    end
  end

  // Output stage: round to Q.8 and saturate.
  logic signed [PW-1:0]         rnd [3];
  logic signed [FORCE_BITS-1:0] sat [3];
  localparam logic signed [PW-1:0] MAXV = (PW'(1) <<< (FORCE_BITS - 1)) - PW'(1);
  localparam logic signed [PW-1:0] MINV = -(PW'(1) <<< (FORCE_BITS - 1));

  always_comb begin
    for (int o = 0; o < 3; o++) begin
      rnd[o] = (sum_r[o] + (PW'(1) <<< 29)) >>> 30;
      if (rnd[o] > MAXV) begin
        sat[o] = MAXV[FORCE_BITS-1:0];
      end else if (rnd[o] < MINV) begin
        sat[o] = MINV[FORCE_BITS-1:0];
      end else begin
        sat[o] = rnd[o][FORCE_BITS-1:0];
      end
    end
  end

  logic signed [FORCE_BITS-1:0] fx_r, fy_r, fz_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      fx_r <= sat[0];
      fy_r <= sat[1];
      fz_r <= sat[2];
    end
  end

  assign out_valid        = v_r[NS+3];
  assign out_body_force_x = fx_r;
  assign out_body_force_y = fy_r;
  assign out_body_force_z = fz_r;

endmodule

[hw/rtl/wbaf_checker.sv]
module wbaf_checker #(
  parameter int FORCE_BITS = wbaf_pkg::DEF_FORCE_BITS
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [FORCE_BITS-1:0] out_body_force_x
);
  import wbaf_pkg::*;

  // The pipeline is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat right after reset");

  // An empty output register never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A stall on the output stalls the input.
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during output stall");

  // A stalled beat holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_body_force_x))
    else $error("stalled output beat changed");

endmodule

bind wind_to_body_axis_force_core wbaf_checker #(.FORCE_BITS(FORCE_BITS)) u_wbaf_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_body_force_x(out_body_force_x));

[verif/wind_to_body_axis_force_core_test.sv]
`timescale 1ns / 1ps

module wind_to_body_axis_force_core_test;
  import wbaf_pkg::*;

  // The run is stopped here if the block stops producing beats.
  localparam int CYCLE_LIMIT = 400000;
  // Pipeline depth of the block, with some margin.
  localparam int SETTLE_CYCLES = 50;

  // Arctangent of 2^-i in 2^-32 turn units, one entry per CORDIC step.
  localparam logic [31:0] ATAN_TURNS [0:29] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } body_force_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic signed [15:0] in_attack_angle;
  logic signed [15:0] in_sideslip_angle;
  logic signed [31:0] in_drag_force;
  logic signed [31:0] in_side_force;
  logic signed [31:0] in_lift_force;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] out_body_force_x;
  logic signed [31:0] out_body_force_y;
  logic signed [31:0] out_body_force_z;

  // Our own copy of the enable mask, updated with every register write.
  logic [2:0] force_mask;
  // Body forces still owed by the block, oldest first.
  body_force_t pending_forces[$];
  int error_count;
  int cycle_count;
  int burst_left;
  int ready_run;
  int ready_stall;

  wind_to_body_axis_force_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_attack_angle(in_attack_angle),
    .in_sideslip_angle(in_sideslip_angle),
    .in_drag_force(in_drag_force),
    .in_side_force(in_side_force),
    .in_lift_force(in_lift_force),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_body_force_x(out_body_force_x),
    .out_body_force_y(out_body_force_y),
    .out_body_force_z(out_body_force_z)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Sine and cosine of a binary angle in Q30. Angles in the second and third
  // quadrants are turned by half a turn first, and both results negated.
  task automatic rotate_unit(input logic [15:0] angle, output longint sin_q30,
                             output longint cos_q30);
    logic [31:0] turn;
    logic mirrored;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    turn = {angle, 16'h0000};
    mirrored = (turn[31:30] == 2'b01) || (turn[31:30] == 2'b10);
    if (mirrored) begin
      turn = turn - 32'h80000000;
    end
    x = longint'(CORDIC_X0);
    y = 0;
    z = longint'(signed'(turn));
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_TURNS[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_TURNS[i]);
      end
    end
    cos_q30 = mirrored ? -x : x;
    sin_q30 = mirrored ? -y : y;
  endtask

  function automatic longint q30_product(input longint a, input longint b);
    return (a * b + (longint'(1) << 29)) >>> 30;
  endfunction

  // Sum of three force-by-coefficient products, rounded back to Q.8 and
  // clamped to the 32-bit signed range. Every term fits well inside 64 bits.
  function automatic logic signed [31:0] rounded_sum(input longint f0, input longint k0,
                                                     input longint f1, input longint k1,
                                                     input longint f2, input longint k2);
    longint total;
    total = (f0 * k0 + f1 * k1 + f2 * k2 + (longint'(1) << 29)) >>> 30;
    if (total > 64'sd2147483647) begin
      total = 64'sd2147483647;
    end
    if (total < -64'sd2147483648) begin
      total = -64'sd2147483648;
    end
    return total[31:0];
  endfunction

  task automatic predict_body_force(input logic [15:0] alpha, input logic [15:0] beta,
                                    input logic signed [31:0] drag,
                                    input logic signed [31:0] side,
                                    input logic signed [31:0] lift,
                                    output body_force_t forces);
    longint sa;
    longint ca;
    longint sb;
    longint cb;
    longint d;
    longint s;
    longint l;
    rotate_unit(alpha, sa, ca);
    rotate_unit(beta, sb, cb);
    d = force_mask[0] ? longint'(drag) : 0;
    s = force_mask[1] ? longint'(side) : 0;
    l = force_mask[2] ? longint'(lift) : 0;
    forces.x = rounded_sum(d, -q30_product(ca, cb), s, -q30_product(ca, sb), l, sa);
    forces.y = rounded_sum(d, -sb, s, cb, l, 0);
    forces.z = rounded_sum(d, -q30_product(sa, cb), s, -q30_product(sa, sb), l, -ca);
  endtask

  // Sends one beat. The sender runs in bursts; when a burst is used up, valid
  // drops for a random gap before the next burst starts.
  task automatic send_sample(input logic [15:0] alpha, input logic [15:0] beta,
                             input logic [31:0] drag, input logic [31:0] side,
                             input logic [31:0] lift);
    body_force_t forces;
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      // Now and then a long burst gives a stretch with no idling at all.
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 12);
    end
    in_attack_angle = alpha;
    in_sideslip_angle = beta;
    in_drag_force = drag;
    in_side_force = side;
    in_lift_force = lift;
    in_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (in_ready) begin
        break;
      end
    end
    predict_body_force(alpha, beta, drag, side, lift, forces);
    pending_forces.push_back(forces);
    burst_left--;
  endtask

  // Stops sending and waits until every owed beat has come out, then lets
  // the pipeline settle.
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_forces.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The mask is written only with the pipeline empty.
  task automatic write_force_mask(input logic [2:0] mask);
    drain_pipeline();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = mask;
    force_mask = mask;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [31:0] random_force();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      1: return 32'($signed($urandom_range(0, 4000)) - 2000);
      2: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] random_angle();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 7) * 16'h2000);
      1: return 16'($urandom_range(0, 3) * 16'h4000 + $urandom_range(0, 4) - 2);
      default: return 16'($urandom);
    endcase
  endfunction

  // Angles at the quadrant boundaries and ends of the range, with the
  // largest forces of both signs so the outputs saturate.
  task automatic test_directed_extremes();
    write_force_mask(3'b111);
    send_sample(16'h0000, 16'h0000, 32'h00000100, 32'h00000200, 32'h00000300);
    send_sample(16'h4000, 16'h0000, 32'h00000100, 32'h00000200, 32'h00000300);
    send_sample(16'hC000, 16'h4000, 32'h00000100, 32'h00000200, 32'h00000300);
    send_sample(16'h8000, 16'hC000, 32'h00001000, 32'hFFFFF000, 32'h00000800);
    send_sample(16'h7FFF, 16'h8000, 32'h00001000, 32'hFFFFF000, 32'h00000800);
    send_sample(16'h3FFF, 16'h4001, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_sample(16'hBFFF, 16'h8001, 32'h80000000, 32'h80000000, 32'h80000000);
    send_sample(16'h2000, 16'h2000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    send_sample(16'hE000, 16'hE000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    send_sample(16'h6000, 16'hA000, 32'hFFFFFFFF, 32'h00000001, 32'h00000000);
    send_sample(16'h0001, 16'hFFFF, 32'h00000000, 32'h00000000, 32'h00000000);
  endtask

  // A cleared mask bit must zero that force whatever its beat carries.
  task automatic test_force_mask();
    logic [2:0] masks [4] = '{3'b000, 3'b001, 3'b010, 3'b100};
    foreach (masks[m]) begin
      write_force_mask(masks[m]);
      send_sample(16'h2000, 16'h1000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      send_sample(16'h9000, 16'hD000, 32'h12345678, 32'hEDCBA987, 32'h0F0F0F0F);
    end
  endtask

  // Random samples in chunks, each chunk under its own mask setting. In the
  // middle of the fourth chunk the sender stops until all results are in.
  task automatic test_random_samples();
    for (int chunk = 0; chunk < 8; chunk++) begin
      write_force_mask((chunk == 0) ? 3'b111 : 3'($urandom_range(0, 7)));
      for (int n = 0; n < 105; n++) begin
        send_sample(random_angle(), random_angle(), random_force(), random_force(),
                    random_force());
        if (chunk == 3 && n == 50) begin
          drain_pipeline();
        end
      end
    end
  endtask

  // Receiver: ready for a random run of cycles, then stalled for a random
  // stretch. Some runs are long so that stretches with no stalls occur.
  always @(negedge clk) begin
    if (ready_run > 0) begin
      out_ready = 1'b1;
      ready_run--;
    end else if (ready_stall > 0) begin
      out_ready = 1'b0;
      ready_stall--;
    end else begin
      ready_run = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                              : $urandom_range(1, 10);
      ready_stall = $urandom_range(1, 8);
      out_ready = 1'b0;
    end
  end

  // Every output beat is checked against the oldest owed result.
  always @(posedge clk) begin
    body_force_t owed;
    if (rst_n && out_valid && out_ready) begin
      if (pending_forces.size() == 0) begin
        $display("%0t: output beat with no result owed (x %0d y %0d z %0d)", $time,
                 out_body_force_x, out_body_force_y, out_body_force_z);
        error_count++;
      end else begin
        owed = pending_forces.pop_front();
        if (out_body_force_x !== owed.x) begin
          $display("%0t: body_force_x expected %0d actual %0d", $time, owed.x,
                   out_body_force_x);
          error_count++;
        end
        if (out_body_force_y !== owed.y) begin
          $display("%0t: body_force_y expected %0d actual %0d", $time, owed.y,
                   out_body_force_y);
          error_count++;
        end
        if (out_body_force_z !== owed.z) begin
          $display("%0t: body_force_z expected %0d actual %0d", $time, owed.z,
                   out_body_force_z);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a hung pipeline ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("wind_to_body_axis_force_core test failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 3'b000;
    in_valid = 1'b0;
    in_attack_angle = '0;
    in_sideslip_angle = '0;
    in_drag_force = '0;
    in_side_force = '0;
    in_lift_force = '0;
    out_ready = 1'b0;
    force_mask = MASK_RESET;
    error_count = 0;
    cycle_count = 0;
    burst_left = 0;
    ready_run = 0;
    ready_stall = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The reset value of the mask enables all forces; check it before any write.
    send_sample(16'h1234, 16'hF00D, 32'h01000000, 32'hFF000000, 32'h00800000);
    test_directed_extremes();
    test_force_mask();
    test_random_samples();
    drain_pipeline();

    if (error_count == 0 && pending_forces.size() == 0) begin
      $display("wind_to_body_axis_force_core test passed");
    end else begin
      $display("wind_to_body_axis_force_core test failed");
    end
    $finish;
  end

endmodule
